FILE: design/mbrtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Item operation codes, CRC-16/MODBUS constants and the one-byte CRC update.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  typedef enum logic [1:0] {
    OP_READ            = 2'd0,
    OP_WRITE_SINGLE    = 2'd1,
    OP_WRITE_MULTI_HDR = 2'd2,
    OP_WRITE_MULTI_VAL = 2'd3
  } op_e;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [15:0] count_or_value;
    logic [15:0] address;
    logic [7:0]  func_code;
    logic [7:0]  unit_id;
    op_e         operation;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/modbus_rtu_request_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// The first byte of an item is offered once the item has passed the input
// register and been loaded into the output buffer; a busy output can delay it.
// One frame byte per cycle while m_axis_tready is high; an item makes 1 (error),
// 2, 4, 7 or 8 bytes.
// The next item waits in an input register while the current one drains.
// Reset clears the open write-multiple frame and sets the CRC to 0xFFFF.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer
  import mbrtu_pkg::*;
#(
  parameter int MAX_REGISTERS = 125
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // unit_id [7:0], func_code [15:8], address [31:16], count_or_value [47:32]
  input  logic [47:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_byte [7:0]
  output logic [7:0]  m_axis_tdata,
  // frame_end
  output logic        m_axis_tlast,
  // error [0]
  output logic        m_axis_tuser
);

  localparam logic [15:0] MaxRegs = 16'(MAX_REGISTERS);

  item_t          item_q;
  logic           item_valid_q, item_valid_d;
  logic           in_beat;

  logic [6:0][7:0] buf_q, buf_d;
  logic [2:0]     data_cnt_q, data_cnt_d;
  logic [1:0]     crc_pend_q, crc_pend_d;
  logic           err_q, err_d;
  logic           out_valid_q, out_valid_d;
  logic [15:0]    crc_q, crc_d;
  logic [6:0]     remaining_q, remaining_d;
  logic           open_q, open_d;

  logic           out_beat, last_beat, ser_free, load;
  logic [15:0]    cv_clamped;
  logic [6:0]     rem_next;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_beat  = out_valid_q && m_axis_tready;
  assign last_beat = err_q || (data_cnt_q == 3'd1 && crc_pend_q == 2'd0) ||
                     (data_cnt_q == 3'd0 && crc_pend_q == 2'd1);
  assign ser_free  = !out_valid_q || (out_beat && last_beat);
  assign load      = item_valid_q && ser_free;
  assign s_axis_tready = !item_valid_q || ser_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = err_q;
  assign m_axis_tlast  = err_q || (data_cnt_q == 3'd0 && crc_pend_q == 2'd1);

  always_comb begin
    if (err_q) begin
      m_axis_tdata = 8'h00;
    end else if (data_cnt_q != 3'd0) begin
      m_axis_tdata = buf_q[0];
    end else if (crc_pend_q == 2'd2) begin
      m_axis_tdata = crc_q[7:0];
    end else begin
      m_axis_tdata = crc_q[15:8];
    end
  end

  assign cv_clamped = (item_q.count_or_value > MaxRegs) ? MaxRegs : item_q.count_or_value;
  assign rem_next   = remaining_q - 7'd1;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_beat) begin
      item_valid_d = 1'b1;
    end else if (load) begin
      item_valid_d = 1'b0;
    end

    buf_d       = buf_q;
    data_cnt_d  = data_cnt_q;
    crc_pend_d  = crc_pend_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    crc_d       = crc_q;
    remaining_d = remaining_q;
    open_d      = open_q;

    if (out_beat) begin
      if (data_cnt_q != 3'd0 && !err_q) begin
        crc_d      = crc_byte(crc_q, buf_q[0]);
        buf_d      = buf_q >> 8;
        data_cnt_d = data_cnt_q - 3'd1;
      end else if (crc_pend_q != 2'd0 && !err_q) begin
        crc_pend_d = crc_pend_q - 2'd1;
        if (crc_pend_q == 2'd1) begin
          crc_d = CrcInit;
        end
      end
      if (last_beat) begin
        out_valid_d = 1'b0;
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
      err_d       = 1'b0;
      data_cnt_d  = 3'd0;
      crc_pend_d  = 2'd0;
      case (item_q.operation)
        OP_WRITE_MULTI_VAL: begin
          if (!open_q) begin
            err_d = 1'b1;
          end else begin
            buf_d[0]    = item_q.count_or_value[15:8];
            buf_d[1]    = item_q.count_or_value[7:0];
            data_cnt_d  = 3'd2;
            remaining_d = rem_next;
            if (rem_next == 7'd0) begin
              crc_pend_d = 2'd2;
              open_d     = 1'b0;
            end
          end
        end
        OP_WRITE_MULTI_HDR: begin
          if (open_q || item_q.count_or_value == 16'd0 ||
              item_q.count_or_value > MaxRegs) begin
            err_d = 1'b1;
          end else begin
            buf_d[0]    = item_q.unit_id;
            buf_d[1]    = item_q.func_code;
            buf_d[2]    = item_q.address[15:8];
            buf_d[3]    = item_q.address[7:0];
            buf_d[4]    = item_q.count_or_value[15:8];
            buf_d[5]    = item_q.count_or_value[7:0];
            buf_d[6]    = {item_q.count_or_value[6:0], 1'b0};
            data_cnt_d  = 3'd7;
            remaining_d = item_q.count_or_value[6:0];
            open_d      = 1'b1;
          end
        end
        OP_READ, OP_WRITE_SINGLE: begin
          if (open_q) begin
            err_d = 1'b1;
          end else begin
            buf_d[0] = item_q.unit_id;
            buf_d[1] = item_q.func_code;
            buf_d[2] = item_q.address[15:8];
            buf_d[3] = item_q.address[7:0];
            if (item_q.operation == OP_READ) begin
              buf_d[4] = cv_clamped[15:8];
              buf_d[5] = cv_clamped[7:0];
            end else begin
              buf_d[4] = item_q.count_or_value[15:8];
              buf_d[5] = item_q.count_or_value[7:0];
            end
            buf_d[6]   = 8'h00;
            data_cnt_d = 3'd6;
            crc_pend_d = 2'd2;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      data_cnt_q   <= 3'd0;
      crc_pend_q   <= 2'd0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      crc_q        <= CrcInit;
      remaining_q  <= 7'd0;
      open_q       <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      data_cnt_q   <= data_cnt_d;
      crc_pend_q   <= crc_pend_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
      crc_q        <= crc_d;
      remaining_q  <= remaining_d;
      open_q       <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q <= item_t'({s_axis_tdata, s_axis_tuser});
    end
    buf_q <= buf_d;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer testbench
// Sends request items to the framer: first a table of directed rows, then
// random reads, single writes and well-formed and broken write-multiple
// sequences. Every output beat is checked against a predictor of the frame
// bytes and the CRC-16/MODBUS. Both stream sides stall at random, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import mbrtu_pkg::*;

  localparam int MaxRegs     = 125;
  localparam int RandomItems = 286;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam int IdlePct     = 28;
  localparam int HoldCycles  = 150;

  typedef struct {
    op_e         op;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] address;
    logic [15:0] count_or_value;
    bit          error_typed;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } frame_beat_t;

  localparam frame_beat_t ErrorBeat = '{data: 8'h00, last: 1'b1, error: 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  frame_beat_t frame_beats_due[$];
  logic [15:0] crc_acc;
  logic [6:0]  regs_due;
  logic        multi_open;
  int          items_sent   = 0;
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  wire steady = (items_sent >= 150) && (items_sent < 220);

  modbus_rtu_request_framer #(
    .MAX_REGISTERS(MaxRegs)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic void queue_beat(input frame_beat_t b);
    frame_beats_due = {frame_beats_due, b};
  endfunction

  task automatic predict_frame(input request_t rq);
    logic [7:0]  fb[7];
    logic [15:0] crc;
    logic [15:0] cnt;
    int          n;
    crc = CrcInit;
    cnt = rq.count_or_value;
    if (rq.op == OP_WRITE_MULTI_VAL) begin
      if (!multi_open) begin
        queue_beat(ErrorBeat);
        return;
      end
      crc = crc16_step(crc16_step(crc_acc, cnt[15:8]), cnt[7:0]);
      queue_beat(frame_beat_t'{cnt[15:8], 1'b0, 1'b0});
      queue_beat(frame_beat_t'{cnt[7:0], 1'b0, 1'b0});
      regs_due = regs_due - 7'd1;
      if (regs_due == 7'd0) begin
        queue_beat(frame_beat_t'{crc[7:0], 1'b0, 1'b0});
        queue_beat(frame_beat_t'{crc[15:8], 1'b1, 1'b0});
        multi_open = 1'b0;
        crc_acc = CrcInit;
      end else begin
        crc_acc = crc;
      end
      return;
    end
    if (multi_open || (rq.op == OP_WRITE_MULTI_HDR && (cnt == 16'd0 || cnt > MaxRegs))) begin
      queue_beat(ErrorBeat);
      return;
    end
    if (rq.op == OP_READ && cnt > MaxRegs) begin
      cnt = 16'(MaxRegs);
    end
    fb = '{rq.unit_id, rq.func_code, rq.address[15:8], rq.address[7:0],
           cnt[15:8], cnt[7:0], {cnt[6:0], 1'b0}};
    n = (rq.op == OP_WRITE_MULTI_HDR) ? 7 : 6;
    for (int i = 0; i < n; i++) begin
      crc = crc16_step(crc, fb[i]);
      queue_beat(frame_beat_t'{fb[i], 1'b0, 1'b0});
    end
    if (rq.op == OP_WRITE_MULTI_HDR) begin
      crc_acc = crc;
      regs_due = cnt[6:0];
      multi_open = 1'b1;
    end else begin
      queue_beat(frame_beat_t'{crc[7:0], 1'b0, 1'b0});
      queue_beat(frame_beat_t'{crc[15:8], 1'b1, 1'b0});
    end
  endtask

  task automatic send_request(input request_t rq);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rq.count_or_value, rq.address, rq.func_code, rq.unit_id};
    s_axis_tuser  <= rq.op;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (rq.error_typed) begin
      queue_beat(ErrorBeat);
    end else begin
      predict_frame(rq);
    end
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("modbus_rtu_request_framer verification failed");
      $finish;
    end
  end

  // The output side checks each beat and then picks its ready for the next cycle.
  initial begin
    frame_beat_t got;
    frame_beat_t want;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (frame_beats_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Unexpected beat: data %h last %b error %b", got.data, got.last, got.error);
          end
        end else begin
          want = frame_beats_due.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("Beat mismatch: expected data %h last %b error %b, got data %h last %b error %b",
                       want.data, want.last, want.error, got.data, got.last, got.error);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && items_sent >= 60) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    request_t dir_rows[24];
    request_t rq;
    int       pick;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_READ;
    crc_acc    = CrcInit;
    regs_due   = 7'd0;
    multi_open = 1'b0;
    dir_rows = '{
      '{OP_READ,            8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0},
      '{OP_READ,            8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{OP_READ,            8'h01, 8'h03, 16'h0000, 16'h000A, 1'b0},
      '{OP_READ,            8'h11, 8'h04, 16'h1234, 16'h007D, 1'b0},
      '{OP_READ,            8'h11, 8'h04, 16'h1234, 16'h007E, 1'b0},
      '{OP_WRITE_SINGLE,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0},
      '{OP_WRITE_SINGLE,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{OP_WRITE_MULTI_HDR, 8'h01, 8'h10, 16'h0000, 16'h0000, 1'b1},
      '{OP_WRITE_MULTI_HDR, 8'h01, 8'h10, 16'h0000, 16'h007E, 1'b1},
      '{OP_WRITE_MULTI_HDR, 8'h01, 8'h10, 16'h0000, 16'hFFFF, 1'b1},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h1234, 1'b1},
      '{OP_WRITE_MULTI_HDR, 8'h01, 8'h10, 16'h0001, 16'h0001, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'hA5, 8'h5A, 16'hFFFF, 16'hFFFF, 1'b0},
      '{OP_WRITE_MULTI_HDR, 8'h7F, 8'h10, 16'h00FF, 16'h0002, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0},
      '{OP_READ,            8'h01, 8'h03, 16'h0000, 16'h0001, 1'b1},
      '{OP_WRITE_SINGLE,    8'h01, 8'h06, 16'h0000, 16'h0001, 1'b1},
      '{OP_WRITE_MULTI_HDR, 8'h01, 8'h10, 16'h0000, 16'h0002, 1'b1},
      '{OP_WRITE_MULTI_VAL, 8'hFF, 8'hFF, 16'h8001, 16'hAAAA, 1'b0},
      '{OP_WRITE_MULTI_HDR, 8'hFF, 8'hFF, 16'hFFFF, 16'h0003, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h5555, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h8000, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h0001, 1'b0},
      '{OP_WRITE_MULTI_VAL, 8'h00, 8'h00, 16'h0000, 16'h0001, 1'b1}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i]);
    end
    // Random part: mostly whole write-multiple sequences, with reads, single writes, stray and bad items mixed in.
    for (int k = 0; k < RandomItems; k++) begin
      rq.unit_id        = 8'($urandom);
      rq.func_code      = 8'($urandom);
      rq.address        = 16'($urandom);
      rq.count_or_value = 16'($urandom);
      rq.error_typed    = 1'b0;
      pick = $urandom_range(99);
      if (multi_open) begin
        rq.op = (pick < 88) ? OP_WRITE_MULTI_VAL : op_e'($urandom_range(2));
      end else if (pick < 22) begin
        rq.op = OP_READ;
        if ($urandom_range(1)) begin
          rq.count_or_value = 16'($urandom_range(MaxRegs, 1));
        end
      end else if (pick < 40) begin
        rq.op = OP_WRITE_SINGLE;
      end else if (pick < 90) begin
        rq.op = OP_WRITE_MULTI_HDR;
        pick = $urandom_range(99);
        if (pick < 65) begin
          rq.count_or_value = 16'($urandom_range(4, 1));
        end else if (pick < 80) begin
          rq.count_or_value = 16'($urandom_range(MaxRegs, 5));
        end else if (pick < 85) begin
          rq.count_or_value = 16'(MaxRegs);
        end else if (pick < 90) begin
          rq.count_or_value = 16'd0;
        end
      end else begin
        rq.op = OP_WRITE_MULTI_VAL;
      end
      send_request(rq);
    end
    s_axis_tvalid <= 1'b0;
    while (frame_beats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("modbus_rtu_request_framer verification clean");
    end else begin
      $display("modbus_rtu_request_framer verification failed");
    end
    $finish;
  end

endmodule
